>>> src/ibof_pkg.sv
// Shared types and constants for the integer binary-op folder.
// No dependencies.
package ibof_pkg;

    localparam int WIDTH = 32;
    localparam int SHW   = $clog2(WIDTH);

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_SDIV = 4'd3,
        OP_UDIV = 4'd4,
        OP_SHL  = 4'd5,
        OP_LSHR = 4'd6,
        OP_ASHR = 4'd7,
        OP_AND  = 4'd8,
        OP_OR   = 4'd9,
        OP_XOR  = 4'd10
    } t_op;

    typedef struct packed {
        logic [3:0]       operation;
        logic [WIDTH-1:0] lhs;
        logic [WIDTH-1:0] rhs;
    } t_req;

    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic             valid_res;
    } t_res;

    // One slot of the divider pipe; non-divide results ride along in alt.
    typedef struct packed {
        logic             vld;
        logic             is_div;
        logic             neg;
        logic             ok;
        logic [WIDTH-1:0] alt;
        logic [WIDTH-1:0] rem;
        logic [WIDTH-1:0] quot;
        logic [WIDTH-1:0] dvs;
    } t_lane;

endpackage

>>> src/integer_binary_op_folder.sv
// Integer binary-op folder: pipelined ALU with a bit-per-stage divider.
// Stages: decode stage, 32 divide steps, result stage.
// Throughput: one beat per cycle; the whole pipe holds on output stall.
// Reset: i_rst_n synchronous, active low, clears all stage valid bits.
// Depends on ibof_pkg and ibof_div_step.
module integer_binary_op_folder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ibof_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output ibof_pkg::t_res  o_res
);

    localparam int W = ibof_pkg::WIDTH;

    // Advance every stage together when the output slot is free or drained.
    logic advance;
    assign advance = !o_valid || i_ready;
    assign o_ready = advance;

    // ---- decode stage: operand magnitudes, non-divide results ----
    ibof_pkg::t_lane n_head;
    ibof_pkg::t_lane r_head;
    logic            sdiv;
    logic            div_op;
    logic            big_sh;
    logic [W-1:0]    a;
    logic [W-1:0]    b;

    always_comb begin
        a      = i_req.lhs;
        b      = i_req.rhs;
        sdiv   = i_req.operation == ibof_pkg::OP_SDIV;
        div_op = sdiv || (i_req.operation == ibof_pkg::OP_UDIV);
        big_sh = b[W-1:ibof_pkg::SHW] != '0;
        n_head        = '0;
        n_head.vld    = i_valid;
        n_head.is_div = div_op;
        n_head.ok     = 1'b1;
        n_head.neg    = sdiv && (a[W-1] ^ b[W-1]);
        n_head.quot   = (sdiv && a[W-1]) ? (W'(0) - a) : a;
        n_head.dvs    = (sdiv && b[W-1]) ? (W'(0) - b) : b;
        case (i_req.operation)
            ibof_pkg::OP_ADD:  n_head.alt = a + b;
            ibof_pkg::OP_SUB:  n_head.alt = a - b;
            ibof_pkg::OP_MUL:  n_head.alt = W'(a * b);
            ibof_pkg::OP_SDIV,
            ibof_pkg::OP_UDIV: n_head.ok  = b != '0;
            ibof_pkg::OP_SHL:  n_head.alt = big_sh ? '0 : (a << b[ibof_pkg::SHW-1:0]);
            ibof_pkg::OP_LSHR: n_head.alt = big_sh ? '0 : (a >> b[ibof_pkg::SHW-1:0]);
            ibof_pkg::OP_ASHR: n_head.alt = big_sh ? {W{a[W-1]}}
                                          : W'($signed(a) >>> b[ibof_pkg::SHW-1:0]);
            ibof_pkg::OP_AND:  n_head.alt = a & b;
            ibof_pkg::OP_OR:   n_head.alt = a | b;
            ibof_pkg::OP_XOR:  n_head.alt = a ^ b;
            default:           n_head.ok  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else if (advance) begin
            r_head.vld <= n_head.vld;
        end
        if (advance) begin
            r_head.is_div <= n_head.is_div;
            r_head.neg    <= n_head.neg;
            r_head.ok     <= n_head.ok;
            r_head.alt    <= n_head.alt;
            r_head.rem    <= n_head.rem;
            r_head.quot   <= n_head.quot;
            r_head.dvs    <= n_head.dvs;
        end
    end

    // ---- divide steps: one quotient bit per stage ----
    ibof_pkg::t_lane lanes [W+1];
    assign lanes[0] = r_head;

    genvar g;
    generate
        for (g = 0; g < W; g++) begin : g_div
            ibof_div_step u_step (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (advance),
                .i_lane (lanes[g]),
                .o_lane (lanes[g+1])
            );
        end
    endgenerate

    // ---- result stage: fix quotient sign, pick result, zero on failure ----
    ibof_pkg::t_lane tail;
    logic            r_out_vld;
    ibof_pkg::t_res  r_res;
    ibof_pkg::t_res  n_res;

    assign tail = lanes[W];

    always_comb begin
        n_res.valid_res = tail.ok;
        if (!tail.ok) begin
            n_res.value = '0;
        end else if (tail.is_div) begin
            n_res.value = tail.neg ? (W'(0) - tail.quot) : tail.quot;
        end else begin
            n_res.value = tail.alt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= tail.vld;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_res;

endmodule

>>> src/ibof_div_step.sv
// One restoring-division step with its pipeline register.
// Depends on ibof_pkg.
module ibof_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  ibof_pkg::t_lane i_lane,
    output ibof_pkg::t_lane o_lane
);

    ibof_pkg::t_lane r_lane;
    ibof_pkg::t_lane n_lane;
    logic [ibof_pkg::WIDTH:0] rem_sh;
    logic [ibof_pkg::WIDTH:0] diff;

    always_comb begin
        rem_sh = {i_lane.rem, i_lane.quot[ibof_pkg::WIDTH-1]};
        diff   = rem_sh - {1'b0, i_lane.dvs};
        n_lane = i_lane;
        if (!diff[ibof_pkg::WIDTH]) begin
            n_lane.rem  = diff[ibof_pkg::WIDTH-1:0];
            n_lane.quot = {i_lane.quot[ibof_pkg::WIDTH-2:0], 1'b1};
        end else begin
            n_lane.rem  = rem_sh[ibof_pkg::WIDTH-1:0];
            n_lane.quot = {i_lane.quot[ibof_pkg::WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_lane.vld <= i_lane.vld;
        end
        if (i_en) begin
            r_lane.is_div <= n_lane.is_div;
            r_lane.neg    <= n_lane.neg;
            r_lane.ok     <= n_lane.ok;
            r_lane.alt    <= n_lane.alt;
            r_lane.rem    <= n_lane.rem;
            r_lane.quot   <= n_lane.quot;
            r_lane.dvs    <= n_lane.dvs;
        end
    end

    assign o_lane = r_lane;

endmodule

>>> test/ibof_checker.sv
`timescale 1ns / 1ps
// Checker for the integer binary-op folder: watches both channels,
// predicts each result and compares it. Depends on ibof_pkg.
module ibof_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_in_ready,
    input  ibof_pkg::t_req i_req,
    input  logic           i_out_valid,
    input  logic           i_ready,
    input  ibof_pkg::t_res i_res,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int W = ibof_pkg::WIDTH;

    ibof_pkg::t_res expected_q[$];
    int             fail_count;
    int             pending;

    function automatic ibof_pkg::t_res fold_op(ibof_pkg::t_req req);
        ibof_pkg::t_res res;
        logic [W-1:0]   a;
        logic [W-1:0]   b;
        logic [W-1:0]   mag_a;
        logic [W-1:0]   mag_b;
        logic [W-1:0]   quot;
        a = req.lhs;
        b = req.rhs;
        res.value = '0;
        res.valid_res = 1'b1;
        case (req.operation)
            ibof_pkg::OP_ADD:  res.value = a + b;
            ibof_pkg::OP_SUB:  res.value = a - b;
            ibof_pkg::OP_MUL:  res.value = a * b;
            ibof_pkg::OP_SDIV: begin
                if (b == 0) begin
                    res.valid_res = 1'b0;
                end else begin
                    mag_a = a[W-1] ? -a : a;
                    mag_b = b[W-1] ? -b : b;
                    quot = mag_a / mag_b;
                    res.value = (a[W-1] != b[W-1]) ? -quot : quot;
                end
            end
            ibof_pkg::OP_UDIV: begin
                if (b == 0) res.valid_res = 1'b0;
                else res.value = a / b;
            end
            ibof_pkg::OP_SHL:  res.value = (b >= W) ? '0 : a << b;
            ibof_pkg::OP_LSHR: res.value = (b >= W) ? '0 : a >> b;
            ibof_pkg::OP_ASHR: begin
                if (b >= W) res.value = {W{a[W-1]}};
                else res.value = $signed(a) >>> b;
            end
            ibof_pkg::OP_AND:  res.value = a & b;
            ibof_pkg::OP_OR:   res.value = a | b;
            ibof_pkg::OP_XOR:  res.value = a ^ b;
            default: res.valid_res = 1'b0;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    always @(posedge i_clk) begin
        ibof_pkg::t_res want;
        if (!i_rst_n) begin
            fail_count = 0;
            pending    = 0;
            expected_q.delete();
        end else begin
            if (i_valid && i_in_ready) expected_q.push_back(fold_op(i_req));
            if (i_out_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected beat", i_res.value, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.value !== want.value)
                        report_mismatch("value", i_res.value, want.value);
                    if (i_res.valid_res !== want.valid_res)
                        report_mismatch("valid_res", {{(W-1){1'b0}}, i_res.valid_res},
                                        {{(W-1){1'b0}}, want.valid_res});
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

>>> test/integer_binary_op_folder_tb.sv
`timescale 1ns / 1ps
// Testbench top for the integer binary-op folder: drives request beats,
// stalls the result side, and reports the verdict. Depends on ibof_pkg, ibof_checker.
module integer_binary_op_folder_tb;

    localparam int W            = ibof_pkg::WIDTH;
    localparam int RANDOM_BEATS = 430;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 60;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    ibof_pkg::t_req i_req;
    logic           o_valid;
    logic           i_ready;
    ibof_pkg::t_res o_res;
    int             fail_count;
    int             pending;
    int             cycle_count;
    bit             quiet_phase;

    integer_binary_op_folder u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res)
    );

    ibof_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_ready(o_ready), .i_req(i_req),
        .i_out_valid(o_valid), .i_ready(i_ready), .i_res(o_res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the pipe locks up.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Draw an operand biased toward edge values: zero, one, all ones,
    // sign boundary, small shift amounts.
    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return {1'b1, {(W-1){1'b0}}};
            4: return {1'b0, {(W-1){1'b1}}};
            5: return $urandom_range(0, W + 4);
            6: return -$urandom_range(1, 16);
            default: return $urandom();
        endcase
    endfunction

    // Send one request beat: hold valid and payload until accepted.
    // Each beat draws its own lead-in gap unless a quiet stretch runs.
    task automatic send_beat(logic [3:0] op, logic [W-1:0] a, logic [W-1:0] b);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= '{operation: op, lhs: a, rhs: b};
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Result side: per beat, stall a random count, then take one beat.
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 12);
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        logic [3:0] op;
        quiet_phase = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every opcode at extremes, plus the special cases.
        for (int k = 0; k <= ibof_pkg::OP_XOR; k++)
            send_beat(4'(k), '1, {1'b1, {(W-1){1'b0}}});
        send_beat(ibof_pkg::OP_SDIV, 32'h1234, '0);                   // divide by zero
        send_beat(ibof_pkg::OP_UDIV, '1, '0);                         // divide by zero
        send_beat(ibof_pkg::OP_SDIV, {1'b1, {(W-1){1'b0}}}, '1);      // min by minus one
        send_beat(ibof_pkg::OP_SDIV, -32'sd7, 32'd2);                 // truncates toward zero
        send_beat(ibof_pkg::OP_SHL, 32'h1, W);                        // shift out of range
        send_beat(ibof_pkg::OP_LSHR, '1, 32'hFFFF_FFFF);
        send_beat(ibof_pkg::OP_ASHR, {1'b1, {(W-1){1'b0}}}, W);       // sign fill
        send_beat(ibof_pkg::OP_ASHR, 32'h7FFF_FFFF, W - 1);
        send_beat(4'd11, 32'h5, 32'h5);                               // unused opcodes
        send_beat(4'd15, '1, '1);
        send_beat(ibof_pkg::OP_ADD, '0, '0);

        // Random: mostly legal ops, a few unused codes; some quiet stretches.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 100 == 0) quiet_phase = !quiet_phase && ($urandom_range(0, 1) == 1);
            if (n % 100 == 30) quiet_phase = 1'b0;
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, ibof_pkg::OP_XOR));
            send_beat(op, pick_operand(), pick_operand());
        end
        i_valid <= 1'b0;
        quiet_phase = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
